// ===== design/dws_pkg.sv =====
// Package for the work-stealing deque unit: opcodes, control states, cell command
// struct and the radix of the tail collection tree. Depends on nothing.
`default_nettype none

package dws_pkg;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_STEAL = 2'd2,
      OP_NONE  = 2'd3
   } dws_op_type;

   // Control states of the top level.
   typedef enum logic {
      ST_IDLE,
      ST_WAIT
   } dws_state_type;

   // Command broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic push;
      logic pop;
      logic steal;
   } dws_cmd_type;

   // Fan-in of each node of the tail collection tree.
   localparam int TREE_RADIX = 16;

   // Number of registered levels needed to reduce depth leaves to one node.
   function automatic int tree_levels(input int depth);
      int lv;
      int span;
      lv = 1;
      span = TREE_RADIX;
      while (span < depth) begin
         span = span * TREE_RADIX;
         lv = lv + 1;
      end
      return lv;
   endfunction

endpackage

`default_nettype wire

// ===== design/dws_cell.sv =====
// One cell of the deque chain: holds one handle and its valid bit.
// Uses dws_pkg for the command struct.
`default_nettype none

module dws_cell #(
   parameter int HANDLE_BITS = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire dws_pkg::dws_cmd_type cmd,
   input  wire                     left_valid,
   input  wire  [HANDLE_BITS-1:0]  left_data,
   input  wire                     right_valid,
   input  wire  [HANDLE_BITS-1:0]  right_data,
   output logic                    valid,
   output logic [HANDLE_BITS-1:0]  data,
   output logic [HANDLE_BITS-1:0]  tap
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [HANDLE_BITS-1:0] data_ff;
   logic [HANDLE_BITS-1:0] data_in;

   // Push shifts toward the older end, pop shifts toward the newer end,
   // and steal drops the oldest entry by clearing the last valid cell.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      priority if (cmd.push) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (cmd.pop) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (cmd.steal) begin
         valid_in = valid_ff & right_valid;
      end else begin
         // No command: the cell keeps its contents.
         valid_in = valid_ff;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The oldest entry is the last valid cell; only that cell drives its tap.
   assign valid = valid_ff;
   assign data  = data_ff;
   assign tap   = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

`default_nettype wire

// ===== design/dws_tail_tree.sv =====
// Registered OR tree that collects the tap of the oldest cell in the chain.
// Uses dws_pkg for the tree radix and the level count function.
`default_nettype none

module dws_tail_tree #(
   parameter int DEPTH       = 256,
   parameter int HANDLE_BITS = 32
) (
   input  wire                          clock,
   input  wire  [DEPTH*HANDLE_BITS-1:0] taps,
   output logic [HANDLE_BITS-1:0]       tail_handle
);

   localparam int RADIX  = dws_pkg::TREE_RADIX;
   localparam int LEVELS = dws_pkg::tree_levels(DEPTH);
   localparam int LEAVES = RADIX ** LEVELS;
   localparam int NODES  = (LEAVES - 1) / (RADIX - 1);

   logic [HANDLE_BITS-1:0] leaf    [LEAVES];
   logic [HANDLE_BITS-1:0] node_ff [NODES];
   logic [HANDLE_BITS-1:0] node_in [NODES];

   // Leaves past the chain length read as zero.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < DEPTH) begin : g_used
         assign leaf[i] = taps[i*HANDLE_BITS +: HANDLE_BITS];
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // Each node ORs its children; at most one tap is nonzero at a time.
   for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      localparam int BASE = (RADIX ** k - 1) / (RADIX - 1);
      localparam int NEXT = (RADIX ** (k + 1) - 1) / (RADIX - 1);
      for (genvar j = 0; j < RADIX ** k; j++) begin : g_node
         logic [HANDLE_BITS-1:0] kid [RADIX];
         for (genvar c = 0; c < RADIX; c++) begin : g_kid
            if (k == LEVELS - 1) begin : g_from_leaf
               assign kid[c] = leaf[RADIX*j + c];
            end else begin : g_from_node
               assign kid[c] = node_ff[NEXT + RADIX*j + c];
            end
         end
         always_comb begin
            node_in[BASE + j] = '0;
            for (int c = 0; c < RADIX; c++) begin
               node_in[BASE + j] = node_in[BASE + j] | kid[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign tail_handle = node_ff[0];

endmodule

`default_nettype wire

// ===== design/work_stealing_deque_unit.sv =====
// Top level of the bounded work-stealing deque: control, response register,
// cell chain and tail tree. Depends on dws_pkg, dws_cell and dws_tail_tree.
//
//   Channel  Direction  Ports                                   Beat carries
//   req      in         req_valid/req_ready                     opcode, job handle
//   rsp      out        rsp_valid/rsp_ready                     success, handle, count, empty
//
// Push, pop, a failed operation and the unused opcode answer in the cycle after the
// request beat. A steal that succeeds waits in ST_WAIT for the registered tail tree
// to settle, then answers once the response register is free.
// One request is in flight at a time; a new beat is taken while the response
// register drains. Reset clears the control state and all cell valid bits.
// A stalled response holds the control in place until it is taken.
`default_nettype none

module work_stealing_deque_unit #(
   parameter int DEPTH       = 256,
   parameter int HANDLE_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [1:0]                        req_opcode,
   input  wire  [HANDLE_BITS-1:0]            req_job_handle,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_success,
   output logic [HANDLE_BITS-1:0]            rsp_taken_handle,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_occupancy,
   output logic                              rsp_is_empty
);

   localparam int OCC_BITS  = $clog2(DEPTH + 1);
   localparam int LEVELS    = dws_pkg::tree_levels(DEPTH);
   localparam int WAIT_BITS = $clog2(LEVELS + 1);

   dws_pkg::dws_state_type state_ff, state_in;
   logic [WAIT_BITS-1:0]   wait_ff, wait_in;
   logic [OCC_BITS-1:0]    count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_success_ff, rsp_success_in;
   logic [HANDLE_BITS-1:0] rsp_taken_ff, rsp_taken_in;
   logic [OCC_BITS-1:0]    rsp_occupancy_ff, rsp_occupancy_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   dws_pkg::dws_cmd_type   cmd;
   dws_pkg::dws_op_type    op;
   logic                   req_fire;
   logic                   rsp_free;
   logic                   load;
   logic                   full;
   logic                   empty;

   logic                   cell_valid [DEPTH];
   logic [HANDLE_BITS-1:0] cell_data  [DEPTH];
   logic [DEPTH*HANDLE_BITS-1:0] taps;
   logic [HANDLE_BITS-1:0] tail_handle;

   assign op       = dws_pkg::dws_op_type'(req_opcode);
   assign full     = (count_ff == OCC_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dws_pkg::ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;

   // Next state, cell command and response load.
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      cmd          = '0;
      load         = 1'b0;
      rsp_success_in = 1'b0;
      rsp_taken_in   = '0;
      unique case (state_ff)
         dws_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (op)
                  dws_pkg::OP_PUSH: begin
                     load = 1'b1;
                     if (!full) begin
                        cmd.push       = 1'b1;
                        count_in       = count_ff + 1'b1;
                        rsp_success_in = 1'b1;
                     end
                  end
                  dws_pkg::OP_POP: begin
                     load = 1'b1;
                     if (!empty) begin
                        cmd.pop        = 1'b1;
                        count_in       = count_ff - 1'b1;
                        rsp_success_in = 1'b1;
                        rsp_taken_in   = cell_data[0];
                     end
                  end
                  dws_pkg::OP_STEAL: begin
                     if (!empty) begin
                        state_in = dws_pkg::ST_WAIT;
                        wait_in  = WAIT_BITS'(LEVELS);
                     end else begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         dws_pkg::ST_WAIT: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (rsp_free) begin
               cmd.steal      = 1'b1;
               load           = 1'b1;
               count_in       = count_ff - 1'b1;
               rsp_success_in = 1'b1;
               rsp_taken_in   = tail_handle;
               state_in       = dws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dws_pkg::ST_IDLE;
         end
      endcase
      rsp_occupancy_in = count_in;
      rsp_empty_in     = (count_in == '0);
      rsp_valid_in     = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dws_pkg::ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register, loaded with each result beat.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_success_ff   <= rsp_success_in;
         rsp_taken_ff     <= rsp_taken_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
         rsp_empty_ff     <= rsp_empty_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_taken_handle = rsp_taken_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;
   assign rsp_is_empty     = rsp_empty_ff;

   // Cell chain: cell zero holds the newest handle, the last valid cell the oldest.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   lv;
      logic [HANDLE_BITS-1:0] ld;
      logic                   rv;
      logic [HANDLE_BITS-1:0] rd;
      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign ld = req_job_handle;
      end else begin : g_mid_l
         assign lv = cell_valid[i-1];
         assign ld = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_mid_r
         assign rv = cell_valid[i+1];
         assign rd = cell_data[i+1];
      end
      dws_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .tap         (taps[i*HANDLE_BITS +: HANDLE_BITS])
      );
   end

   // Collects the oldest handle for steal.
   dws_tail_tree #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_tail_tree (
      .clock       (clock),
      .taps        (taps),
      .tail_handle (tail_handle)
   );

   // The head cell is occupied exactly when the deque holds something.
   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell valid disagrees with the count");

   // The last cell is occupied exactly when the deque is full.
   a_tail_matches_full: assert property (@(posedge clock) disable iff (reset)
      cell_valid[DEPTH-1] == full)
      else $error("last cell valid disagrees with the full flag");

   // An accepted push that fits lands its handle in the head cell.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_fire && op == dws_pkg::OP_PUSH && !full)
      |=> (cell_data[0] == $past(req_job_handle)))
      else $error("pushed handle missing from the head cell");

   // While a steal waits for the tree, no new request beat is taken.
   a_wait_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dws_pkg::ST_WAIT) |-> !req_ready)
      else $error("request accepted during a steal");

endmodule

`default_nettype wire

// ===== test/dws_checker.sv =====
// Scoreboard for the work-stealing deque unit: watches the request and response
// channels, predicts each response from its own copy of the deque and compares.
// Depends on dws_pkg for the opcode type.
module dws_checker #(
   parameter int DEPTH       = 256,
   parameter int HANDLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [HANDLE_BITS-1:0]       req_job_handle,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_success,
   input  logic [HANDLE_BITS-1:0]       rsp_taken_handle,
   input  logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   input  logic                         rsp_is_empty,
   output int                           mismatches,
   output int                           awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PTR_BITS = $clog2(DEPTH) + 1;
   localparam int OCC_BITS = $clog2(DEPTH + 1);

   typedef struct packed {
      logic                   success;
      logic [HANDLE_BITS-1:0] handle;
      logic [OCC_BITS-1:0]    count;
      logic                   empty;
   } deque_result_type;

   // Shadow deque. The pointers count modulo twice the depth so that a full
   // deque and an empty one can be told apart.
   logic [HANDLE_BITS-1:0] slots [DEPTH];
   logic [PTR_BITS-1:0]    head_ptr;
   logic [PTR_BITS-1:0]    tail_ptr;
   deque_result_type       result_fifo [$];
   int                     errs;
   int                     rsp_beats;

   // Carries out one operation on the shadow deque and returns its response.
   function automatic deque_result_type apply_deque_op(
      input dws_pkg::dws_op_type    op,
      input logic [HANDLE_BITS-1:0] handle);
      deque_result_type    r;
      logic [PTR_BITS-1:0] fill;
      logic [PTR_BITS-1:0] last;
      r = '0;
      fill = tail_ptr - head_ptr;
      last = tail_ptr - 1'b1;
      case (op)
         dws_pkg::OP_PUSH: begin
            if (fill < DEPTH) begin
               slots[tail_ptr[PTR_BITS-2:0]] = handle;
               tail_ptr = tail_ptr + 1'b1;
               r.success = 1'b1;
            end
         end
         dws_pkg::OP_POP: begin
            if (fill != 0) begin
               r.handle = slots[last[PTR_BITS-2:0]];
               // Taking the only element moves the front up to meet the back.
               if (fill == 1)
                  head_ptr = head_ptr + 1'b1;
               else
                  tail_ptr = last;
               r.success = 1'b1;
            end
         end
         dws_pkg::OP_STEAL: begin
            if (fill != 0) begin
               r.handle = slots[head_ptr[PTR_BITS-2:0]];
               head_ptr = head_ptr + 1'b1;
               r.success = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.count = tail_ptr - head_ptr;
      r.empty = (tail_ptr == head_ptr);
      return r;
   endfunction

   // Predict on every request beat and compare on every response beat.
   always @(posedge clock) begin
      deque_result_type got;
      deque_result_type want;
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         result_fifo.delete();
         errs = 0;
         rsp_beats = 0;
         mismatches <= 0;
         awaited <= 0;
      end else begin
         if (req_valid && req_ready)
            result_fifo.push_back(
               apply_deque_op(dws_pkg::dws_op_type'(req_opcode), req_job_handle));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_success, rsp_taken_handle, rsp_occupancy, rsp_is_empty};
            if (result_fifo.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("response beat %0d arrived with no request waiting", rsp_beats);
            end else begin
               want = result_fifo.pop_front();
               if (got.success !== want.success || got.handle !== want.handle ||
                   got.count !== want.count || got.empty !== want.empty) begin
                  errs++;
                  if (errs <= 10)
                     $display({"response beat %0d: expected success %0b handle %h ",
                               "count %0d empty %0b, got success %0b handle %h ",
                               "count %0d empty %0b"},
                              rsp_beats, want.success, want.handle, want.count, want.empty,
                              got.success, got.handle, got.count, got.empty);
               end
            end
            rsp_beats++;
         end
         mismatches <= errs;
         awaited <= result_fifo.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
// Top of the work-stealing deque testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on dws_pkg,
// work_stealing_deque_unit and dws_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 256;
   localparam int HANDLE_BITS  = 32;
   localparam int OCC_BITS     = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 1300;
   // Longest correct quiet stretch is the deliberate response hold-off plus the
   // steal wait and idling; allow several times that.
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic [1:0]             req_opcode = 2'b00;
   logic [HANDLE_BITS-1:0] req_job_handle = '0;
   logic                   rsp_ready = 1'b0;
   wire                    req_ready;
   wire                    rsp_valid;
   wire                    rsp_success;
   wire [HANDLE_BITS-1:0]  rsp_taken_handle;
   wire [OCC_BITS-1:0]     rsp_occupancy;
   wire                    rsp_is_empty;
   int                     mismatches;
   int                     awaited;

   typedef struct {
      dws_pkg::dws_op_type    op;
      logic [HANDLE_BITS-1:0] handle;
   } deque_cmd_type;

   typedef enum {
      PH_FILL,
      PH_DRAIN,
      PH_MIX
   } load_phase_type;

   deque_cmd_type  directed_cmds [$];
   load_phase_type phase = PH_MIX;
   int             level_est = 0;
   int             linger = 0;
   int             mix_left = 60;
   int             quiet = 0;

   work_stealing_deque_unit #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_job_handle   (req_job_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_success      (rsp_success),
      .rsp_taken_handle (rsp_taken_handle),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty)
   );

   dws_checker #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_job_handle   (req_job_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_success      (rsp_success),
      .rsp_taken_handle (rsp_taken_handle),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .mismatches       (mismatches),
      .awaited          (awaited)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Draws an opcode with the given percentages; the remainder is the unused code.
   function automatic dws_pkg::dws_op_type pick_op(input int p_push, input int p_pop,
                                                    input int p_steal);
      int r;
      r = $urandom_range(99, 0);
      if (r < p_push)
         return dws_pkg::OP_PUSH;
      else if (r < p_push + p_pop)
         return dws_pkg::OP_POP;
      else if (r < p_push + p_pop + p_steal)
         return dws_pkg::OP_STEAL;
      return dws_pkg::OP_NONE;
   endfunction

   // Next command: the directed list first, then random traffic that swings the
   // deque from empty to full and back, lingering a few beats at each extreme.
   task automatic next_cmd(output deque_cmd_type c);
      if (directed_cmds.size() != 0) begin
         c = directed_cmds.pop_front();
      end else begin
         c.handle = $urandom();
         case (phase)
            PH_FILL: begin
               c.op = pick_op(85, 5, 7);
               if (level_est == DEPTH) begin
                  if (linger == 0) begin
                     phase = PH_DRAIN;
                     linger = $urandom_range(8, 3);
                  end else
                     linger--;
               end
            end
            PH_DRAIN: begin
               c.op = pick_op(12, 40, 45);
               if (level_est == 0) begin
                  if (linger == 0) begin
                     phase = PH_MIX;
                     mix_left = $urandom_range(120, 40);
                  end else
                     linger--;
               end
            end
            default: begin
               c.op = pick_op(40, 27, 27);
               if (mix_left == 0) begin
                  phase = PH_FILL;
                  linger = $urandom_range(8, 3);
               end else
                  mix_left--;
            end
         endcase
      end
      // Track the fill level so the phases know where the deque stands.
      if (c.op == dws_pkg::OP_PUSH && level_est < DEPTH)
         level_est++;
      else if ((c.op == dws_pkg::OP_POP || c.op == dws_pkg::OP_STEAL) && level_est > 0)
         level_est--;
   endtask

   // Request side: directed beats, then random ones, with random gaps.
   initial begin
      int            sent;
      int            made;
      int            total;
      bit            loaded;
      deque_cmd_type cur;
      // Empty deque: every way to fail, then single-element pop and steal.
      directed_cmds.push_back('{dws_pkg::OP_STEAL, 32'h1111_1111});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h2222_2222});
      directed_cmds.push_back('{dws_pkg::OP_NONE,  32'hFFFF_FFFF});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'hFFFF_FFFF});
      directed_cmds.push_back('{dws_pkg::OP_STEAL, 32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h0000_0000});
      // A few elements: pop returns the newest, steal the oldest.
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'h8000_0000});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'h7FFF_FFFF});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'hA5A5_A5A5});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'h5A5A_5A5A});
      directed_cmds.push_back('{dws_pkg::OP_NONE,  32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'hFFFF_FFFF});
      directed_cmds.push_back('{dws_pkg::OP_STEAL, 32'hFFFF_FFFF});
      directed_cmds.push_back('{dws_pkg::OP_STEAL, 32'h0000_0001});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h0000_0001});
      directed_cmds.push_back('{dws_pkg::OP_STEAL, 32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'h0000_0001});
      directed_cmds.push_back('{dws_pkg::OP_PUSH,  32'hFFFF_FFFE});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h0000_0000});
      directed_cmds.push_back('{dws_pkg::OP_POP,   32'h0000_0000});
      total = directed_cmds.size() + RANDOM_ITEMS;
      sent = 0;
      made = 0;
      loaded = 1'b0;
      while (reset)
         @(posedge clock);
      while (sent < total) begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            sent++;
            loaded = 1'b0;
         end
         if (!loaded && made < total) begin
            next_cmd(cur);
            made++;
            loaded = 1'b1;
         end
         // A beat that is still waiting stays put; otherwise offer or idle.
         if (req_valid && !req_ready) begin
         end else if (loaded && ((sent >= 500 && sent < 800) ||
                                 $urandom_range(99, 0) >= 10)) begin
            req_valid <= 1'b1;
            req_opcode <= cur.op;
            req_job_handle <= cur.handle;
         end else
            req_valid <= 1'b0;
      end
      // Let every response come back, then watch a little longer.
      do
         @(posedge clock);
      while (awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls, a calm stretch, and one long hold-off that
   // backs the block up while requests keep coming.
   initial begin
      int taken;
      int hold_left;
      bit held_once;
      taken = 0;
      hold_left = 0;
      held_once = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            taken++;
         if (!held_once && taken == 150) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= (taken >= 500 && taken < 800) || $urandom_range(99, 0) >= 10;
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

// ===== work_stealing_deque_unit.f =====
design/dws_pkg.sv
design/dws_cell.sv
design/dws_tail_tree.sv
design/work_stealing_deque_unit.sv
test/dws_checker.sv
test/testbench.sv
